// ===== sv/ba_pkg.sv =====
// Shared constants, datapath commands and controller/datapath signal groups.
`timescale 1ns / 1ps
`default_nettype none
package ba_pkg;
  localparam int unsigned POOL_UNITS = 64;
  localparam int unsigned NUM_ORDERS = 7;
  localparam int unsigned OFF_W      = $clog2(POOL_UNITS);
  localparam int unsigned ORD_W      = $clog2(NUM_ORDERS);
  localparam int unsigned SIZE_W     = 7;
  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(NUM_ORDERS - 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_REM_RD,
    OP_REM_W,
    OP_PUSH_RD,
    OP_PUSH_W1,
    OP_PUSH_W2,
    OP_FREE_RD,
    OP_FREE_CHK,
    OP_MERGE_RD,
    OP_MERGE_CK,
    OP_DONE
  } ba_op_e;

  typedef struct packed {
    ba_op_e op;
  } ba_cmd_t;

  typedef struct packed {
    logic is_free;     // latched item is a free
    logic alloc_ok;    // incoming allocate finds a list that fits
    logic chk_bad;     // free target is not a busy block start
    logic split_none;  // allocated block needs no split
    logic list_empty;  // target list of the push is empty
    logic push_last;   // this push ends the item
    logic merge_top;   // no buddy to look at
    logic merge_no;    // buddy is busy or of another order
  } ba_status_t;
endpackage
`default_nettype wire

// ===== sv/ba_ctrl.sv =====
// Controller state machine that sequences the table steps of one item.
`timescale 1ns / 1ps
`default_nettype none
module ba_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  ba_pkg::ba_status_t st_i,
  output ba_pkg::ba_cmd_t    cmd_o
);
  import ba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_REM_RD, S_REM_W, S_PUSH_RD, S_PUSH_W1, S_PUSH_W2,
    S_FREE_RD, S_FREE_CHK, S_MERGE_RD, S_MERGE_CK, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;
  logic   push_end_next;

  assign load          = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;

  always_comb begin
    cmd_o.op       = OP_NONE;
    state_d        = state_q;
    push_end_next  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          if (!st_i.is_free) state_d = st_i.alloc_ok ? S_REM_RD : S_DONE;
          else state_d = S_FREE_RD;
        end
      end
      S_REM_RD: begin
        cmd_o.op = OP_REM_RD;
        state_d  = S_REM_W;
      end
      S_REM_W: begin
        cmd_o.op = OP_REM_W;
        state_d  = st_i.split_none ? S_DONE : S_PUSH_RD;
      end
      S_PUSH_RD: begin
        cmd_o.op = OP_PUSH_RD;
        if (st_i.list_empty) push_end_next = 1'b1;
        else state_d = S_PUSH_W1;
      end
      S_PUSH_W1: begin
        cmd_o.op = OP_PUSH_W1;
        state_d  = S_PUSH_W2;
      end
      S_PUSH_W2: begin
        cmd_o.op      = OP_PUSH_W2;
        push_end_next = 1'b1;
      end
      S_FREE_RD: begin
        cmd_o.op = OP_FREE_RD;
        state_d  = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd_o.op = OP_FREE_CHK;
        state_d  = st_i.chk_bad ? S_DONE : S_MERGE_RD;
      end
      S_MERGE_RD: begin
        cmd_o.op = OP_MERGE_RD;
        state_d  = st_i.merge_top ? S_PUSH_RD : S_MERGE_CK;
      end
      S_MERGE_CK: begin
        cmd_o.op = OP_MERGE_CK;
        state_d  = st_i.merge_no ? S_PUSH_RD : S_MERGE_RD;
      end
      S_DONE: begin
        if (load) begin
          cmd_o.op = OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (push_end_next) state_d = st_i.push_last ? S_DONE : S_PUSH_RD;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/ba_dpath.sv =====
// Datapath: link, order and tag tables, list heads and the result register.
`timescale 1ns / 1ps
`default_nettype none
module ba_dpath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  ba_pkg::ba_cmd_t           cmd_i,
  output ba_pkg::ba_status_t        st_o,
  input  wire                       cmd_in_i,
  input  wire [ba_pkg::SIZE_W-1:0]  req_size_i,
  input  wire [ba_pkg::OFF_W-1:0]   block_offset_i,
  output logic [1:0]                status_o,
  output logic [ba_pkg::OFF_W-1:0]  out_offset_o,
  output logic [ba_pkg::ORD_W-1:0]  out_order_o
);
  import ba_pkg::*;

  // Tables live in plain memories; entry 0 reads its reset value until written.
  logic [OFF_W-1:0] nl_mem [POOL_UNITS];
  logic [OFF_W-1:0] pl_mem [POOL_UNITS];
  logic [ORD_W-1:0] bo_mem [POOL_UNITS];
  logic             bt_mem [POOL_UNITS];

  logic [OFF_W-1:0] nl_ra, pl_ra, bo_ra, bt_ra;
  logic [OFF_W-1:0] nl_wa, pl_wa, bo_wa, bt_wa;
  logic [OFF_W-1:0] nl_wd, pl_wd;
  logic [ORD_W-1:0] bo_wd;
  logic             bt_wd;
  logic             nl_we, pl_we, bo_we, bt_we;
  logic [OFF_W-1:0] nl_rq, pl_rq;
  logic [ORD_W-1:0] bo_rq;
  logic             bt_rq;
  logic [3:0]       fresh_q, fresh_d, sel0_q;
  logic [OFF_W-1:0] nl_rd, pl_rd;
  logic [ORD_W-1:0] bo_rd;
  logic             bt_rd;

  logic [POOL_UNITS-1:0] start_q, start_d;
  logic [OFF_W-1:0]      head_q [NUM_ORDERS];
  logic [NUM_ORDERS-1:0] lvalid_q, lvalid_d;
  logic [OFF_W-1:0]      head_d [NUM_ORDERS];

  logic             is_free_q;
  logic [ORD_W-1:0] need_q, k_q, o_q, o_d;
  logic [OFF_W-1:0] n_q, n_d, tail_q;
  logic [1:0]       stat_q, stat_d;
  logic [1:0]       res_stat_q;
  logic [OFF_W-1:0] res_off_q;
  logic [ORD_W-1:0] res_ord_q;

  logic [ORD_W-1:0] need_c, k_c, rm_ord;
  logic             fits_c, found_c;
  logic [OFF_W-1:0] x, h, b, rm_node;

  always_comb begin
    need_c = '0;
    fits_c = 1'b0;
    for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
      if ((SIZE_W'(1) << i) >= req_size_i) begin
        need_c = ORD_W'(i);
        fits_c = 1'b1;
      end
    end
    k_c     = '0;
    found_c = 1'b0;
    for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
      if (lvalid_q[i] && ORD_W'(i) >= need_c) begin
        k_c     = ORD_W'(i);
        found_c = 1'b1;
      end
    end
    found_c = found_c && fits_c;
  end

  assign x       = is_free_q ? n_q : n_q + (OFF_W'(1) << o_q);
  assign h       = head_q[o_q];
  assign b       = n_q ^ (OFF_W'(1) << o_q);
  assign rm_node = (cmd_i.op == OP_REM_W) ? n_q : b;
  assign rm_ord  = (cmd_i.op == OP_REM_W) ? k_q : o_q;

  assign nl_rd = sel0_q[0] ? OFF_W'(0) : nl_rq;
  assign pl_rd = sel0_q[1] ? OFF_W'(0) : pl_rq;
  assign bo_rd = sel0_q[2] ? TOP_ORD   : bo_rq;
  assign bt_rd = sel0_q[3] ? 1'b0      : bt_rq;

  assign st_o.is_free    = (cmd_i.op == OP_LATCH) ? cmd_in_i : is_free_q;
  assign st_o.alloc_ok   = found_c;
  assign st_o.chk_bad    = !start_q[n_q] || !bt_rd;
  assign st_o.split_none = (need_q == k_q);
  assign st_o.list_empty = !lvalid_q[o_q];
  assign st_o.push_last  = is_free_q || (o_q + ORD_W'(1) == k_q);
  assign st_o.merge_top  = (o_q == TOP_ORD) || !start_q[b];
  assign st_o.merge_no   = bt_rd || (bo_rd != o_q);

  always_comb begin
    nl_ra = '0; pl_ra = '0; bo_ra = '0; bt_ra = '0;
    nl_we = 1'b0; pl_we = 1'b0; bo_we = 1'b0; bt_we = 1'b0;
    nl_wa = '0; pl_wa = '0; bo_wa = '0; bt_wa = '0;
    nl_wd = '0; pl_wd = '0; bo_wd = '0; bt_wd = 1'b0;
    start_d  = start_q;
    lvalid_d = lvalid_q;
    for (int i = 0; i < NUM_ORDERS; i++) head_d[i] = head_q[i];
    n_d    = n_q;
    o_d    = o_q;
    stat_d = stat_q;
    case (cmd_i.op)
      OP_LATCH: begin
        stat_d = ST_OK;
        if (cmd_in_i == CMD_ALLOC) begin
          n_d = head_q[k_c];
          o_d = need_c;
          if (!found_c) stat_d = ST_NO_SPACE;
        end else begin
          n_d = block_offset_i;
        end
      end
      OP_REM_RD: begin
        nl_ra = n_q;
        pl_ra = n_q;
      end
      OP_FREE_RD: begin
        bo_ra = n_q;
        bt_ra = n_q;
      end
      OP_FREE_CHK: begin
        if (st_o.chk_bad) begin
          stat_d = ST_BAD_FREE;
        end else begin
          o_d   = bo_rd;
          bt_we = 1'b1;
          bt_wa = n_q;
          bt_wd = 1'b0;
        end
      end
      OP_MERGE_RD: begin
        nl_ra = b; pl_ra = b; bo_ra = b; bt_ra = b;
      end
      OP_PUSH_RD: begin
        bo_we = 1'b1; bo_wa = x; bo_wd = o_q;
        bt_we = 1'b1; bt_wa = x; bt_wd = 1'b0;
        start_d[x] = 1'b1;
        pl_ra = h;
        if (!lvalid_q[o_q]) begin
          nl_we = 1'b1; nl_wa = x; nl_wd = x;
          pl_we = 1'b1; pl_wa = x; pl_wd = x;
          head_d[o_q]   = x;
          lvalid_d[o_q] = 1'b1;
          if (!is_free_q) o_d = o_q + ORD_W'(1);
        end
      end
      OP_PUSH_W1: begin
        nl_we = 1'b1; nl_wa = x; nl_wd = h;
        pl_we = 1'b1; pl_wa = x; pl_wd = pl_rd;
      end
      OP_PUSH_W2: begin
        nl_we = 1'b1; nl_wa = tail_q; nl_wd = x;
        pl_we = 1'b1; pl_wa = h;      pl_wd = x;
        head_d[o_q]   = x;
        lvalid_d[o_q] = 1'b1;
        if (!is_free_q) o_d = o_q + ORD_W'(1);
      end
      default: ;
    endcase

    // Unlinking a node is shared by the allocate and the merge steps.
    if (cmd_i.op == OP_REM_W || (cmd_i.op == OP_MERGE_CK && !st_o.merge_no)) begin
      if (nl_rd == rm_node) begin
        lvalid_d[rm_ord] = 1'b0;
      end else begin
        nl_we = 1'b1; nl_wa = pl_rd; nl_wd = nl_rd;
        pl_we = 1'b1; pl_wa = nl_rd; pl_wd = pl_rd;
        head_d[rm_ord] = nl_rd;
      end
      if (cmd_i.op == OP_REM_W) begin
        bo_we = 1'b1; bo_wa = n_q; bo_wd = need_q;
        bt_we = 1'b1; bt_wa = n_q; bt_wd = 1'b1;
      end else begin
        if (b < n_q) begin
          start_d[n_q] = 1'b0;
          n_d          = b;
        end else begin
          start_d[b] = 1'b0;
        end
        o_d   = o_q + ORD_W'(1);
        bo_we = 1'b1;
        bo_wa = (b < n_q) ? b : n_q;
        bo_wd = o_q + ORD_W'(1);
      end
    end

    fresh_d = fresh_q;
    if (nl_we && nl_wa == '0) fresh_d[0] = 1'b0;
    if (pl_we && pl_wa == '0) fresh_d[1] = 1'b0;
    if (bo_we && bo_wa == '0) fresh_d[2] = 1'b0;
    if (bt_we && bt_wa == '0) fresh_d[3] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    if (bo_we) bo_mem[bo_wa] <= bo_wd;
    if (bt_we) bt_mem[bt_wa] <= bt_wd;
    nl_rq <= nl_mem[nl_ra];
    pl_rq <= pl_mem[pl_ra];
    bo_rq <= bo_mem[bo_ra];
    bt_rq <= bt_mem[bt_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= '1;
      sel0_q   <= '0;
      start_q  <= POOL_UNITS'(1);
      lvalid_q <= NUM_ORDERS'(1) << (NUM_ORDERS - 1);
      for (int i = 0; i < NUM_ORDERS; i++) head_q[i] <= '0;
    end else begin
      fresh_q  <= fresh_d;
      sel0_q   <= {fresh_q[3] && bt_ra == '0, fresh_q[2] && bo_ra == '0,
                   fresh_q[1] && pl_ra == '0, fresh_q[0] && nl_ra == '0};
      start_q  <= start_d;
      lvalid_q <= lvalid_d;
      for (int i = 0; i < NUM_ORDERS; i++) head_q[i] <= head_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      is_free_q <= cmd_in_i;
      need_q    <= need_c;
      k_q       <= k_c;
    end
    if (cmd_i.op == OP_PUSH_W1) tail_q <= pl_rd;
    n_q    <= n_d;
    o_q    <= o_d;
    stat_q <= stat_d;
    if (cmd_i.op == OP_DONE) begin
      res_stat_q <= stat_q;
      res_off_q  <= (stat_q == ST_OK) ? n_q : '0;
      res_ord_q  <= (stat_q != ST_OK) ? '0 : (is_free_q ? o_q : need_q);
    end
  end

  assign status_o     = res_stat_q;
  assign out_offset_o = res_off_q;
  assign out_order_o  = res_ord_q;
endmodule
`default_nettype wire

// ===== sv/buddy_allocator.sv =====
// Top level of the buddy allocator: controller plus table datapath.
//
// A 64-unit pool is managed in power-of-two blocks of order 0 to 6. Each
// input item carries cmd_i (allocate or free), req_size_i and block_offset_i;
// each accepted item yields exactly one result item with status_o,
// out_offset_o and out_order_o. Both channels use valid/ready.
// The block takes one item at a time. The tables sit in single-write-port
// memories with registered reads, so every list step is a read step and
// one or two write steps. An allocate latches the item, reads and unlinks
// the head block, then per split pushes the upper half: a read and, unless
// the target list is empty, two writes. A free latches, reads and checks
// the block, then per merge reads and checks the buddy, and ends with a
// push. A no-space allocate, and a bad free after its check, go to finish.
// The result sits in an output register; while the receiver stalls it holds
// there and the block waits in its finish step before taking the next item.
// After reset the pool is one free block of order 6 at offset 0. No clearing
// pass is needed: entry 0 reads its reset value until first written.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire                       cmd_i,
  input  wire [ba_pkg::SIZE_W-1:0]  req_size_i,
  input  wire [ba_pkg::OFF_W-1:0]   block_offset_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [1:0]                status_o,
  output logic [ba_pkg::OFF_W-1:0]  out_offset_o,
  output logic [ba_pkg::ORD_W-1:0]  out_order_o
);
  import ba_pkg::*;

  ba_cmd_t    cmd;
  ba_status_t st;

  ba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ba_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .cmd_in_i       (cmd_i),
    .req_size_i     (req_size_i),
    .block_offset_i (block_offset_i),
    .status_o       (status_o),
    .out_offset_o   (out_offset_o),
    .out_order_o    (out_order_o)
  );
endmodule
`default_nettype wire

// ===== sv/ba_checker.sv =====
// Port-level checks of the buddy allocator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module ba_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire [1:0]                status_o,
  input wire [ba_pkg::OFF_W-1:0]  out_offset_o,
  input wire [ba_pkg::ORD_W-1:0]  out_order_o
);
  import ba_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_offset_o))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (status_o == ST_OK || status_o == ST_NO_SPACE || status_o == ST_BAD_FREE))
    else $error("unknown status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      out_offset_o == OFF_W'(0) && out_order_o == ORD_W'(0))
    else $error("error result with nonzero fields");

  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      out_order_o <= TOP_ORD &&
      ((out_offset_o & ((OFF_W'(1) << out_order_o) - OFF_W'(1))) == OFF_W'(0)))
    else $error("block not aligned to its order");
endmodule

bind buddy_allocator ba_checker u_ba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_offset_o (out_offset_o),
  .out_order_o  (out_order_o)
);
`default_nettype wire
